>>> rtl/core/sdcf_pkg.sv
// shared types, constants and crc helper for the sd command frame builder
package sdcf_pkg;

    localparam logic [7:0] IDLE_BYTE      = 8'hFF;
    localparam logic [7:0] START_BITS     = 8'h40;
    localparam logic [7:0] INDEX_MASK     = 8'h3F;
    localparam logic [7:0] CRC7_POLY_ALN  = 8'h12;
    localparam logic [7:0] FIXED_CRC_BYTE = 8'h95;
    localparam logic [7:0] CRC_KEEP_MASK  = 8'hFE;
    localparam logic [7:0] CRC_END_BIT    = 8'h01;

    // byte positions inside the eight-byte frame
    localparam logic [2:0] POS_IDLE_HEAD = 3'd0;
    localparam logic [2:0] POS_START     = 3'd1;
    localparam logic [2:0] POS_ARG3      = 3'd2;
    localparam logic [2:0] POS_ARG2      = 3'd3;
    localparam logic [2:0] POS_ARG1      = 3'd4;
    localparam logic [2:0] POS_ARG0      = 3'd5;
    localparam logic [2:0] POS_CRC       = 3'd6;
    localparam logic [2:0] POS_LAST      = 3'd7;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // one command as it travels down the crc pipeline
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [31:0] arg;
        logic        crc_en;
        logic [7:0]  crc;
    } sdcf_item_t;

    // crc-7 register (aligned to the top seven bits) advanced over one byte
    function automatic logic [7:0] crc7_update(input logic [7:0] crc_in,
                                               input logic [7:0] data);
        logic [7:0] r;
        r = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ CRC7_POLY_ALN;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/sdcf_crc_pipe.sv
// three-stage crc-7 pipeline over the five command bytes
module sdcf_crc_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          cmd_index,
    input  logic [31:0]         command_argument,
    input  logic                crc_enable,
    output logic                out_valid,
    input  logic                out_ready,
    output sdcf_pkg::sdcf_item_t out_item
);
    import sdcf_pkg::*;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    sdcf_item_t s1_reg, s2_reg, s3_reg;
    sdcf_item_t s1_next, s2_next, s3_next;
    logic       rdy1, rdy2, rdy3;
    logic [7:0] crc_s3;

    // stage advances when empty or when the next stage takes its item
    assign rdy3     = !s3_valid_reg || out_ready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: start byte and top argument byte
    always_comb
    begin
        s1_next.start_byte = START_BITS | (cmd_index & INDEX_MASK);
        s1_next.arg        = command_argument;
        s1_next.crc_en     = crc_enable;
        s1_next.crc        = crc7_update(crc7_update(8'h00, s1_next.start_byte),
                                         command_argument[31:24]);
    end

    // stage 2: middle argument bytes
    always_comb
    begin
        s2_next     = s1_reg;
        s2_next.crc = crc7_update(crc7_update(s1_reg.crc, s1_reg.arg[23:16]),
                                  s1_reg.arg[15:8]);
    end

    // stage 3: last argument byte and final crc byte (fixed 0x95 when crc is disabled)
    always_comb
    begin
        crc_s3  = crc7_update(s2_reg.crc, s2_reg.arg[7:0]);
        s3_next = s2_reg;
        if (s2_reg.crc_en)
            s3_next.crc = (crc_s3 & CRC_KEEP_MASK) | CRC_END_BIT;
        else
            s3_next.crc = FIXED_CRC_BYTE;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            s1_reg <= s1_next;
        if (rdy2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (rdy3 && s2_valid_reg)
            s3_reg <= s3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_reg;

endmodule

>>> rtl/core/sdcf_serializer.sv
// frame holding register and byte serializer with registered output
module sdcf_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdcf_pkg::sdcf_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           tx_byte,
    output logic [2:0]           byte_position,
    output logic                 last
);
    import sdcf_pkg::*;

    sdcf_item_t frame_reg;
    logic       frame_valid_reg;
    logic [2:0] cnt_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic [2:0] pos_reg;
    logic       last_reg;
    logic       out_load, emit, last_emit, take;
    logic [7:0] byte_next;

    assign out_load  = !out_valid_reg || out_ready;
    assign emit      = out_load && frame_valid_reg;
    assign last_emit = emit && (cnt_reg == POS_LAST);
    assign in_ready  = !frame_valid_reg || last_emit;
    assign take      = in_ready && in_valid;

    // byte select by position
    always_comb
    begin
        unique case (cnt_reg)
            POS_IDLE_HEAD: byte_next = IDLE_BYTE;
            POS_START:     byte_next = frame_reg.start_byte;
            POS_ARG3:      byte_next = frame_reg.arg[31:24];
            POS_ARG2:      byte_next = frame_reg.arg[23:16];
            POS_ARG1:      byte_next = frame_reg.arg[15:8];
            POS_ARG0:      byte_next = frame_reg.arg[7:0];
            POS_CRC:       byte_next = frame_reg.crc;
            POS_LAST:      byte_next = IDLE_BYTE;
            default:       byte_next = IDLE_BYTE;
        endcase
    end

    // frame control and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            cnt_reg         <= POS_IDLE_HEAD;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                frame_valid_reg <= 1'b1;
                cnt_reg         <= POS_IDLE_HEAD;
            end
            else
            begin
                if (last_emit)
                    frame_valid_reg <= 1'b0;
                if (emit)
                    cnt_reg <= cnt_reg + 3'd1;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame and output payload
    always_ff @(posedge clk)
    begin
        if (take)
            frame_reg <= in_item;
        if (emit)
        begin
            byte_reg <= byte_next;
            pos_reg  <= cnt_reg;
            last_reg <= (cnt_reg == POS_LAST);
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_byte       = byte_reg;
    assign byte_position = pos_reg;
    assign last          = last_reg;

endmodule

>>> rtl/core/sd_command_frame_builder_core.sv
// top level: sd spi command frame builder with crc-7
// path: a command transfer loads crc stage 1; its frame's first byte then passes through
// crc stages 2 and 3, the frame register and the output register before it is valid
// throughput: one frame byte per cycle on the output while m_axis_tready does not stall it
// the crc stages take a new command every cycle unless stalled; the output byte port sets the rate
// reset: async active low, clears all valid bits, crc_enable resets to 1
module sd_command_frame_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // crc_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [7:0] cmd_index, [39:8] command_argument
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] tx_byte, [10:8] byte_position, zero pad
    output logic        m_axis_tlast
);
    import sdcf_pkg::*;

    logic       crc_enable_reg;
    logic       mid_valid, mid_ready;
    sdcf_item_t mid_item;
    logic [7:0] tx_byte;
    logic [2:0] byte_position;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_enable_reg <= 1'b1;
        else if (cfg_wr_en)
            crc_enable_reg <= cfg_wr_data;
    end

    sdcf_crc_pipe u_crc_pipe (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .cmd_index        (s_axis_tdata[7:0]),
        .command_argument (s_axis_tdata[39:8]),
        .crc_enable       (crc_enable_reg),
        .out_valid        (mid_valid),
        .out_ready        (mid_ready),
        .out_item         (mid_item)
    );

    sdcf_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (mid_valid),
        .in_ready      (mid_ready),
        .in_item       (mid_item),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .tx_byte       (tx_byte),
        .byte_position (byte_position),
        .last          (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, byte_position, tx_byte};

`ifndef NO_ASSERTIONS
    // a frame goes out without gaps once started
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a frame");

    // positions count up byte by byte
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tdata[10:8] == 3'($past(m_axis_tdata[10:8]) + 3'd1))
        else $error("byte position out of sequence");

    // the frame opens with the idle byte
    a_head_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10:8] == POS_IDLE_HEAD |->
        m_axis_tdata[7:0] == IDLE_BYTE)
        else $error("frame does not open with idle byte");
`endif

endmodule
